[rtl/trs_pkg.sv]
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, rotor wirings and modulo-26 helpers for the rotor scrambler.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int LETTER_W   = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 8;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 8;

    typedef logic [LETTER_W-1:0] letter_t;

    localparam letter_t LETTERS      = letter_t'(26);
    localparam letter_t NOTCH_FIRST  = letter_t'(17);
    localparam letter_t NOTCH_SECOND = letter_t'(5);

    typedef enum logic [MODE_W-1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_BACKWARD = 2'd1,
        MODE_STEP     = 2'd2,
        MODE_LOAD     = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FIRST  = 2'd0,
        CFG_START_SECOND = 2'd1,
        CFG_START_THIRD  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef letter_t wiring_t [26];

    localparam wiring_t FWD_FIRST = '{
        5'd9, 5'd6, 5'd3, 5'd16, 5'd14, 5'd23, 5'd20, 5'd18, 5'd2, 5'd0, 5'd12, 5'd8, 5'd5,
        5'd17, 5'd21, 5'd19, 5'd15, 5'd13, 5'd4, 5'd22, 5'd10, 5'd1, 5'd11, 5'd25, 5'd24, 5'd7};
    localparam wiring_t FWD_SECOND = '{
        5'd13, 5'd19, 5'd25, 5'd15, 5'd18, 5'd5, 5'd1, 5'd14, 5'd10, 5'd12, 5'd22, 5'd17, 5'd2,
        5'd9, 5'd3, 5'd8, 5'd21, 5'd11, 5'd0, 5'd4, 5'd24, 5'd20, 5'd23, 5'd7, 5'd6, 5'd16};
    localparam wiring_t FWD_THIRD = '{
        5'd9, 5'd21, 5'd8, 5'd20, 5'd1, 5'd7, 5'd19, 5'd2, 5'd3, 5'd24, 5'd0, 5'd10, 5'd4,
        5'd16, 5'd25, 5'd15, 5'd14, 5'd18, 5'd6, 5'd23, 5'd13, 5'd17, 5'd12, 5'd22, 5'd5, 5'd11};
    localparam wiring_t INV_FIRST = '{
        5'd9, 5'd21, 5'd8, 5'd2, 5'd18, 5'd12, 5'd1, 5'd25, 5'd11, 5'd0, 5'd20, 5'd22, 5'd10,
        5'd17, 5'd4, 5'd16, 5'd3, 5'd13, 5'd7, 5'd15, 5'd6, 5'd14, 5'd19, 5'd5, 5'd24, 5'd23};
    localparam wiring_t INV_SECOND = '{
        5'd18, 5'd6, 5'd12, 5'd14, 5'd19, 5'd5, 5'd24, 5'd23, 5'd15, 5'd13, 5'd8, 5'd17, 5'd9,
        5'd0, 5'd7, 5'd3, 5'd25, 5'd11, 5'd4, 5'd1, 5'd21, 5'd16, 5'd10, 5'd22, 5'd20, 5'd2};
    localparam wiring_t INV_THIRD = '{
        5'd10, 5'd4, 5'd7, 5'd8, 5'd12, 5'd24, 5'd18, 5'd5, 5'd2, 5'd0, 5'd11, 5'd25, 5'd22,
        5'd20, 5'd16, 5'd15, 5'd13, 5'd21, 5'd17, 5'd6, 5'd3, 5'd1, 5'd23, 5'd19, 5'd9, 5'd14};

    // values 26..31 fold down by 26
    function automatic letter_t fold26(letter_t v);
        return (v >= LETTERS) ? letter_t'(v - LETTERS) : v;
    endfunction

    // both operands in 0..25
    function automatic letter_t add_mod26(letter_t a, letter_t b);
        logic [LETTER_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, LETTERS}) ? letter_t'(sum - {1'b0, LETTERS}) : sum[LETTER_W-1:0];
    endfunction

    function automatic letter_t sub_mod26(letter_t a, letter_t b);
        return (a >= b) ? letter_t'(a - b) : letter_t'(a + LETTERS - b);
    endfunction

    function automatic letter_t inc_mod26(letter_t a);
        return (a == letter_t'(LETTERS - 1'b1)) ? '0 : letter_t'(a + 1'b1);
    endfunction

    function automatic letter_t rotor_stage(wiring_t wiring, letter_t x, letter_t p);
        letter_t idx;
        idx = add_mod26(x, p);
        return sub_mod26(wiring[idx], p);
    endfunction

endpackage

[rtl/three_rotor_scrambler.sv]
// ----------------------------------------------------------------------------
// three_rotor_scrambler
// Three-rotor letter scrambler with forward and backward passes and stepping.
// ----------------------------------------------------------------------------
// One word is taken per clock while the output is not stalled, and each gives
// one result word. A word passes an input register, then one pass of rotor
// lookups and modulo-26 adds, stepping or loading of the rotor positions, into
// the output register. While the output word waits, the input register still
// takes one more word. Mode 0 scrambles forward through rotors one to three,
// mode 1 backward through the inverse wirings, mode 2 steps the rotors and
// mode 3 loads the start positions; modes 2 and 3 return 0. Start positions
// must be written on the cfg port while idle; the block does not enforce it.
module three_rotor_scrambler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trs_pkg::S_DATA_W-1:0]    s_tdata,   // [4:0] letter_in
    input  logic [trs_pkg::S_USER_W-1:0]    s_tuser,   // [1:0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trs_pkg::M_DATA_W-1:0]    m_tdata,   // [4:0] letter_out
    input  logic                            cfg_wr_en,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trs_pkg::LETTER_W-1:0]    cfg_wdata
);
    import trs_pkg::*;

    logic    in_valid_reg;
    mode_t   mode_reg;
    letter_t letter_reg;
    logic    out_valid_reg;
    letter_t out_letter_reg;

    letter_t pos_first_reg,  pos_first_next;
    letter_t pos_second_reg, pos_second_next;
    letter_t pos_third_reg,  pos_third_next;
    letter_t start_first_reg, start_second_reg, start_third_reg;

    logic    out_free;
    logic    advance;
    letter_t letter_in_fold;
    letter_t fwd_a, fwd_b, fwd_c;
    letter_t bwd_a, bwd_b, bwd_c;
    letter_t result;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_letter_reg);

    assign letter_in_fold = fold26(letter_reg);
    assign fwd_a = rotor_stage(FWD_FIRST,  letter_in_fold, pos_first_reg);
    assign fwd_b = rotor_stage(FWD_SECOND, fwd_a,          pos_second_reg);
    assign fwd_c = rotor_stage(FWD_THIRD,  fwd_b,          pos_third_reg);
    assign bwd_a = rotor_stage(INV_THIRD,  letter_in_fold, pos_third_reg);
    assign bwd_b = rotor_stage(INV_SECOND, bwd_a,          pos_second_reg);
    assign bwd_c = rotor_stage(INV_FIRST,  bwd_b,          pos_first_reg);

    always_comb begin
        result          = '0;
        pos_first_next  = pos_first_reg;
        pos_second_next = pos_second_reg;
        pos_third_next  = pos_third_reg;
        unique case (mode_reg)
            MODE_FORWARD: begin
                result = fwd_c;
            end
            MODE_BACKWARD: begin
                result = bwd_c;
            end
            MODE_STEP: begin
                pos_first_next = inc_mod26(pos_first_reg);
                if (pos_first_next == NOTCH_FIRST) begin
                    pos_second_next = inc_mod26(pos_second_reg);
                    if (pos_second_next == NOTCH_SECOND) begin
                        pos_third_next = inc_mod26(pos_third_reg);
                    end
                end
            end
            MODE_LOAD: begin
                pos_first_next  = fold26(start_first_reg);
                pos_second_next = fold26(start_second_reg);
                pos_third_next  = fold26(start_third_reg);
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_first_reg    <= '0;
            pos_second_reg   <= '0;
            pos_third_reg    <= '0;
            start_first_reg  <= '0;
            start_second_reg <= '0;
            start_third_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                pos_first_reg  <= pos_first_next;
                pos_second_reg <= pos_second_next;
                pos_third_reg  <= pos_third_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_START_FIRST:  start_first_reg  <= cfg_wdata;
                    CFG_START_SECOND: start_second_reg <= cfg_wdata;
                    CFG_START_THIRD:  start_third_reg  <= cfg_wdata;
                    CFG_UNUSED:       ;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mode_reg   <= mode_t'(s_tuser[MODE_W-1:0]);
            letter_reg <= s_tdata[LETTER_W-1:0];
        end
        if (advance) begin
            out_letter_reg <= result;
        end
    end

endmodule

[rtl/trs_checker.sv]
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks for the rotor scrambler, bound to the top level.
// ----------------------------------------------------------------------------
module trs_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [trs_pkg::M_DATA_W-1:0]    m_tdata
);
    import trs_pkg::*;

    // output empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // letters stay within the alphabet, upper bits zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LETTER_W-1:0] < LETTERS) && (m_tdata[M_DATA_W-1:LETTER_W] == '0))
        else $error("result letter out of range");

    // input only stalls behind a full output stage
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with free output stage");

endmodule

bind three_rotor_scrambler trs_checker u_trs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/three_rotor_scrambler_tb.sv]
// ----------------------------------------------------------------------------
// three_rotor_scrambler_tb
// Stream bench for the three-rotor scrambler: a queue-fed driver sends mode
// and letter words with random gaps, a monitor takes results under random
// back-pressure and checks each one against a predictor of the rotor passes,
// stepping and loading. Start positions are rewritten between phases.
// ----------------------------------------------------------------------------
module three_rotor_scrambler_tb;
    import trs_pkg::*;

    typedef struct packed {
        mode_t          mode;
        logic [4:0]     letter;
    } scr_word_t;

    localparam int IDLE_LIMIT = 4000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;    // [4:0] letter_in
    logic [S_USER_W-1:0]    s_tuser   = '0;    // [1:0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;           // [4:0] letter_out
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [LETTER_W-1:0]    cfg_wdata = '0;

    scr_word_t      pending_words[$];
    logic [4:0]     expected_letters[$];
    int             errors       = 0;
    int             gap_left     = 0;
    int             stall_left   = 0;
    int             idle_cycles  = 0;
    bit             steady_phase = 1'b0;

    // predictor state
    logic [4:0]     rot_first, rot_second, rot_third;
    logic [4:0]     start_first, start_second, start_third;

    int wire_fwd [3][26] = '{
        '{9,6,3,16,14,23,20,18,2,0,12,8,5,17,21,19,15,13,4,22,10,1,11,25,24,7},
        '{13,19,25,15,18,5,1,14,10,12,22,17,2,9,3,8,21,11,0,4,24,20,23,7,6,16},
        '{9,21,8,20,1,7,19,2,3,24,0,10,4,16,25,15,14,18,6,23,13,17,12,22,5,11}};
    int wire_inv [3][26] = '{
        '{9,21,8,2,18,12,1,25,11,0,20,22,10,17,4,16,3,13,7,15,6,14,19,5,24,23},
        '{18,6,12,14,19,5,24,23,15,13,8,17,9,0,7,3,25,11,4,1,21,16,10,22,20,2},
        '{10,4,7,8,12,24,18,5,2,0,11,25,22,20,16,15,13,21,17,6,3,1,23,19,9,14}};

    three_rotor_scrambler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic [4:0] fold_letter(logic [4:0] v);
        return (v >= 5'd26) ? v - 5'd26 : v;
    endfunction

    function automatic logic [4:0] next_pos(logic [4:0] p);
        return (p == 5'd25) ? 5'd0 : p + 5'd1;
    endfunction

    function automatic int pass_rotor(int rotor, bit inverse, int x, int p);
        int idx;
        int y;
        idx = (x + p) % 26;
        y   = inverse ? wire_inv[rotor][idx] : wire_fwd[rotor][idx];
        return (y + 26 - p) % 26;
    endfunction

    function logic [4:0] scramble_word(mode_t mode, logic [4:0] letter);
        int x;
        x = int'(fold_letter(letter));
        case (mode)
            MODE_FORWARD: begin
                x = pass_rotor(0, 1'b0, x, int'(rot_first));
                x = pass_rotor(1, 1'b0, x, int'(rot_second));
                x = pass_rotor(2, 1'b0, x, int'(rot_third));
            end
            MODE_BACKWARD: begin
                x = pass_rotor(2, 1'b1, x, int'(rot_third));
                x = pass_rotor(1, 1'b1, x, int'(rot_second));
                x = pass_rotor(0, 1'b1, x, int'(rot_first));
            end
            MODE_STEP: begin
                rot_first = next_pos(rot_first);
                if (rot_first == 5'd17) begin
                    rot_second = next_pos(rot_second);
                    if (rot_second == 5'd5)
                        rot_third = next_pos(rot_third);
                end
                x = 0;
            end
            default: begin
                rot_first  = fold_letter(start_first);
                rot_second = fold_letter(start_second);
                rot_third  = fold_letter(start_third);
                x = 0;
            end
        endcase
        return 5'(x);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s, got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin : drive_words
        logic       next_valid;
        scr_word_t  w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_letters.push_back(scramble_word(mode_t'(s_tuser), s_tdata[4:0]));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_tdata    <= {3'b000, w.letter};
                    s_tuser    <= w.mode;
                    next_valid = 1'b1;
                    gap_left   <= pick_gap(steady_phase);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // monitor
    always @(posedge aclk) begin : check_words
        logic [4:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_letters.size() == 0) begin
                report_mismatch("word with nothing expected", int'(m_tdata), 0);
            end else begin
                want = expected_letters.pop_front();
                if (m_tdata !== {3'b000, want})
                    report_mismatch("letter_out", int'(m_tdata), int'(want));
            end
        end
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left <= pick_gap(steady_phase);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_start(cfg_idx_t idx, logic [4:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_START_FIRST:  start_first  = val;
            CFG_START_SECOND: start_second = val;
            CFG_START_THIRD:  start_third  = val;
            default: ;
        endcase
    endtask

    task automatic set_starts(logic [4:0] a, logic [4:0] b, logic [4:0] c, bit poke_unused);
        write_start(CFG_START_FIRST, a);
        write_start(CFG_START_SECOND, b);
        write_start(CFG_START_THIRD, c);
        if (poke_unused)
            write_start(CFG_UNUSED, 5'($urandom_range(0, 31)));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic add_word(mode_t mode, logic [4:0] letter);
        scr_word_t w;
        w.mode   = mode;
        w.letter = letter;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_letters.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [4:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return ($urandom_range(0, 1) != 0) ? 5'd25 : 5'd0;
        else if (r < 25)
            return 5'($urandom_range(26, 31));
        else if (r < 50)
            return 5'($urandom_range(0, 1) != 0 ? $urandom_range(12, 16) : $urandom_range(2, 4));
        return 5'($urandom_range(0, 25));
    endfunction

    function automatic mode_t pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return MODE_LOAD;
        else if (r < 40)
            return MODE_STEP;
        else if (r < 70)
            return MODE_FORWARD;
        return MODE_BACKWARD;
    endfunction

    function automatic logic [4:0] pick_letter();
        if ($urandom_range(0, 99) < 15)
            return 5'($urandom_range(26, 31));
        return 5'($urandom_range(0, 25));
    endfunction

    initial begin
        rot_first    = '0;
        rot_second   = '0;
        rot_third    = '0;
        start_first  = '0;
        start_second = '0;
        start_third  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset positions first, then notch carry through all three rotors
        set_starts(5'd16, 5'd4, 5'd25, 1'b0);
        add_word(MODE_FORWARD, 5'd0);
        add_word(MODE_FORWARD, 5'd25);
        add_word(MODE_FORWARD, 5'd31);
        add_word(MODE_BACKWARD, 5'd0);
        add_word(MODE_BACKWARD, 5'd25);
        add_word(MODE_BACKWARD, 5'd26);
        add_word(MODE_LOAD, 5'd31);
        add_word(MODE_FORWARD, 5'd0);
        add_word(MODE_STEP, 5'd0);
        add_word(MODE_FORWARD, 5'd7);
        add_word(MODE_BACKWARD, 5'd7);
        add_word(MODE_STEP, 5'd31);
        wait_drained();

        // out-of-range starts fold, the unused index is ignored
        set_starts(5'd31, 5'd26, 5'd0, 1'b1);
        add_word(MODE_LOAD, 5'd0);
        add_word(MODE_BACKWARD, 5'd31);
        add_word(MODE_FORWARD, 5'd26);
        add_word(MODE_STEP, 5'd12);
        add_word(MODE_FORWARD, 5'd12);
        wait_drained();

        // rotor one and rotor two wrap
        set_starts(5'd16, 5'd25, 5'd25, 1'b0);
        add_word(MODE_LOAD, 5'd0);
        add_word(MODE_STEP, 5'd0);
        add_word(MODE_FORWARD, 5'd31);
        add_word(MODE_BACKWARD, 5'd30);
        wait_drained();
        set_starts(5'd25, 5'd25, 5'd25, 1'b0);
        add_word(MODE_LOAD, 5'd0);
        add_word(MODE_STEP, 5'd0);
        add_word(MODE_FORWARD, 5'd13);
        wait_drained();

        for (int phase = 0; phase < 14; phase++) begin
            steady_phase = ($urandom_range(0, 3) == 0);
            set_starts(pick_start(), pick_start(), pick_start(), $urandom_range(0, 4) == 0);
            add_word(MODE_LOAD, pick_letter());
            for (int n = 0; n < 124; n++)
                add_word(pick_mode(), pick_letter());
            wait_drained();
        end

        steady_phase = 1'b0;
        repeat (8) @(negedge aclk);
        if (expected_letters.size() != 0)
            report_mismatch("words never returned", 0, expected_letters.size());
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
rtl/trs_pkg.sv
rtl/three_rotor_scrambler.sv
rtl/trs_checker.sv
bench/three_rotor_scrambler_tb.sv
